/* rtl/svq_pkg.sv */
// svq_pkg: shared types and constants for the split virtqueue descriptor manager
// no dependencies; imported by svq_front, svq_back and the top level
package svq_pkg;

  localparam logic [15:0] CHAIN_END        = 16'hffff;
  localparam logic [7:0]  QUEUE_SIZE_RESET = 8'd128;

  localparam logic [1:0] KIND_DESC   = 2'd0;
  localparam logic [1:0] KIND_AVAIL  = 2'd1;
  localparam logic [1:0] KIND_POLL   = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_BADID   = 3'd4;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_POLL = 1'b1
  } op_e_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] buf_addr;
    logic [31:0] buf_len;
    logic        dev_writable;
    logic [7:0]  chain_length;
    logic [31:0] token;
    logic [15:0] device_used_index;
    logic [15:0] used_id;
    logic [31:0] used_len;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [15:0] slot_index;
    logic [63:0] desc_addr;
    logic [31:0] desc_len;
    logic [1:0]  desc_flags;
    logic [15:0] desc_next;
    logic [15:0] published_index;
    logic [31:0] ret_token;
    logic [31:0] ret_len;
    logic        last;
  } result_t;

  // request as classified by the front end
  typedef struct packed {
    op_e_t op;
    item_t it;
  } cmd_t;

endpackage

/* rtl/split_virtqueue_descriptor_manager.sv */
// split_virtqueue_descriptor_manager: top level, driver side of a split virtqueue
// depends on svq_pkg, svq_front and svq_back
//
// An add request runs through the execute state, and also through the publish
// state when it closes a chain (descriptor result, then avail result); a poll
// walks its chain back onto the free list one descriptor at a time, bounded by
// the queue size. Results appear for one cycle on result_valid and cannot be
// held off. A request queue of two lets start be taken while the back end works.
// After reset and every queue_size write the descriptor memories are swept over
// all MAX_QUEUE entries, with busy high; rejected chain tails give no result.
module split_virtqueue_descriptor_manager import svq_pkg::*; #(
  parameter int MAX_QUEUE = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  item_t      item,
  output logic       result_valid,
  output result_t    result,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic clearing;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  svq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .clearing  (clearing),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  svq_back #(.MAX_QUEUE(MAX_QUEUE)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

/* rtl/svq_front.sv */
// svq_front: accepts requests, classifies them and holds them in a two-entry queue
// depends on svq_pkg
module svq_front import svq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  item_t item,
  input  logic  clearing,
  output logic  busy,
  output logic  cmd_valid,
  output cmd_t  cmd,
  input  logic  cmd_pop
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy      = clearing || (count == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].op <= item.mode ? OP_POLL : OP_ADD;
      q[wr_ptr].it <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

/* rtl/svq_back.sv */
// svq_back: executes add and poll requests against the descriptor tables
// depends on svq_pkg; owns the link, next-flag and token memories
module svq_back import svq_pkg::*; #(
  parameter int MAX_QUEUE = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       clearing,
  output logic       result_valid,
  output result_t    result
);

  localparam int IW = $clog2(MAX_QUEUE);
  localparam int QW = $clog2(MAX_QUEUE + 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_PUB   = 5'b01000,
    S_WALK  = 5'b10000
  } state_t;

  function automatic logic [QW-1:0] map_size(input logic [7:0] qs);
    if (qs == 8'd0 || 32'(qs) > MAX_QUEUE) return QW'(MAX_QUEUE);
    return QW'(qs);
  endfunction

  logic [15:0] link_mem [MAX_QUEUE];
  logic        more_mem [MAX_QUEUE];
  logic [31:0] tok_mem  [MAX_QUEUE];
  logic [15:0] link_rd;
  logic        more_rd;
  logic [31:0] tok_rd;

  state_t      state, state_next;
  logic [QW-1:0] qsize;
  logic [IW-1:0] clr_idx, clr_idx_next;
  logic [15:0] fl_head, fl_head_next;
  logic [QW-1:0] free_count, free_count_next;
  logic [15:0] avail_index, avail_index_next;
  logic [IW-1:0] avail_slot, avail_slot_next;
  logic [15:0] used_seen, used_seen_next;
  logic [7:0]  chain_pos, chain_pos_next;
  logic [15:0] chain_head, chain_head_next;
  logic        chain_rej, chain_rej_next;
  cmd_t        cur, cur_next;
  logic [IW-1:0] h, h_next;
  logic [QW-1:0] steps, steps_next;
  logic        fwd, fwd_next;
  logic [15:0] fwd_link, fwd_link_next;
  logic [31:0] tok, tok_next;
  result_t     res_next;
  logic        res_valid_next;

  logic [IW-1:0] rd_addr;
  logic          lw_en, mw_en, tw_en;
  logic [IW-1:0] lw_addr, tw_addr;
  logic [15:0]   lw_data;
  logic          mw_data;
  logic [31:0]   tw_data;

  // walk step helpers
  logic [IW-1:0] h_cur;
  logic [15:0]   link_eff;
  logic          more_eff;
  logic [QW-1:0] steps_inc;
  logic          walk_done;
  // add helpers
  logic [8:0]    pos_inc;
  logic          nat_last;
  logic          fh_ok;
  logic [QW-1:0] fc_dec;
  logic          final_buf;
  logic [15:0]   clr_link;

  assign clearing = (state == S_CLEAR);
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;

  always_comb begin
    h_cur     = (state == S_EXEC) ? cur.it.used_id[IW-1:0] : h;
    link_eff  = fwd ? fwd_link : link_rd;
    more_eff  = fwd ? 1'b0 : more_rd;
    steps_inc = steps + QW'(1);
    walk_done = !more_eff || (link_eff >= 16'(qsize)) || (steps_inc >= qsize);
    pos_inc   = {1'b0, chain_pos} + 9'd1;
    nat_last  = pos_inc >= {1'b0, cur.it.chain_length};
    fh_ok     = fl_head < 16'(qsize);
    fc_dec    = free_count - QW'(1);
    final_buf = nat_last || (fc_dec == '0);
    clr_link  = ((16'(clr_idx) + 16'd1) < 16'(qsize)) ? (16'(clr_idx) + 16'd1) : CHAIN_END;
  end

  always_comb begin
    state_next       = state;
    clr_idx_next     = clr_idx;
    fl_head_next     = fl_head;
    free_count_next  = free_count;
    avail_index_next = avail_index;
    avail_slot_next  = avail_slot;
    used_seen_next   = used_seen;
    chain_pos_next   = chain_pos;
    chain_head_next  = chain_head;
    chain_rej_next   = chain_rej;
    cur_next         = cur;
    h_next           = h;
    steps_next       = steps;
    fwd_next         = 1'b0;
    fwd_link_next    = fwd_link;
    tok_next         = tok;
    res_next         = '0;
    res_valid_next   = 1'b0;
    rd_addr          = fl_head[IW-1:0];
    lw_en   = 1'b0; lw_addr = h_cur; lw_data = fl_head;
    mw_en   = 1'b0; mw_data = 1'b0;
    tw_en   = 1'b0; tw_addr = h_cur; tw_data = '0;

    case (state)
      S_CLEAR: begin
        lw_en = 1'b1; lw_addr = clr_idx; lw_data = clr_link;
        mw_en = 1'b1;
        tw_en = 1'b1; tw_addr = clr_idx;
        clr_idx_next = clr_idx + IW'(1);
        if (clr_idx == IW'(MAX_QUEUE - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cur_next   = cmd;
          rd_addr    = (cmd.op == OP_POLL) ? cmd.it.used_id[IW-1:0] : fl_head[IW-1:0];
          steps_next = '0;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cur.op == OP_ADD) begin
          state_next = S_IDLE;
          res_next.last = 1'b1;
          res_next.kind = KIND_REJECT;
          if (chain_rej) begin
            if (nat_last) begin
              chain_pos_next = '0; chain_rej_next = 1'b0;
            end else begin
              chain_pos_next = pos_inc[7:0];
            end
          end else if (chain_pos == 8'd0 && cur.it.chain_length == 8'd0) begin
            res_valid_next  = 1'b1;
            res_next.status = ST_INVALID;
          end else if (chain_pos == 8'd0 &&
                       (16'(cur.it.chain_length) > 16'(free_count) || !fh_ok)) begin
            res_valid_next  = 1'b1;
            res_next.status = ST_NOSPACE;
            if (cur.it.chain_length > 8'd1) begin
              chain_rej_next = 1'b1; chain_pos_next = 8'd1;
            end
          end else if (chain_pos != 8'd0 && (free_count == '0 || !fh_ok)) begin
            res_valid_next  = 1'b1;
            res_next.status = ST_NOSPACE;
            if (nat_last) begin
              chain_pos_next = '0; chain_rej_next = 1'b0;
            end else begin
              chain_pos_next = pos_inc[7:0]; chain_rej_next = 1'b1;
            end
          end else begin
            if (chain_pos == 8'd0) begin
              chain_head_next = fl_head;
              tw_en = 1'b1; tw_addr = fl_head[IW-1:0]; tw_data = cur.it.token;
            end
            fl_head_next    = link_rd;
            free_count_next = fc_dec;
            lw_en = 1'b1; lw_addr = fl_head[IW-1:0];
            lw_data = final_buf ? CHAIN_END : link_rd;
            mw_en = 1'b1; mw_data = !final_buf;
            res_valid_next      = 1'b1;
            res_next.kind       = KIND_DESC;
            res_next.status     = ST_OK;
            res_next.slot_index = fl_head;
            res_next.desc_addr  = cur.it.buf_addr;
            res_next.desc_len   = cur.it.buf_len;
            res_next.desc_flags = {cur.it.dev_writable, !final_buf};
            res_next.desc_next  = final_buf ? CHAIN_END : link_rd;
            // the avail result follows and carries last when the chain closes
            res_next.last       = !final_buf;
            if (!final_buf) begin
              chain_pos_next = pos_inc[7:0];
            end else begin
              state_next = S_PUB;
              if (nat_last) begin
                chain_pos_next = '0; chain_rej_next = 1'b0;
              end else begin
                chain_pos_next = pos_inc[7:0]; chain_rej_next = 1'b1;
              end
            end
          end
        end else begin
          res_next.kind = KIND_POLL;
          res_next.last = 1'b1;
          if ((chain_pos != 8'd0 && !chain_rej) || used_seen == cur.it.device_used_index) begin
            res_valid_next  = 1'b1;
            res_next.status = ST_EMPTY;
            state_next      = S_IDLE;
          end else if (cur.it.used_id >= 16'(qsize)) begin
            res_valid_next  = 1'b1;
            res_next.status = ST_BADID;
            state_next      = S_IDLE;
          end else begin
            tok_next = tok_rd;
            tw_en    = 1'b1;
            // keep the head entry on the read port for the first walk step
            rd_addr  = cur.it.used_id[IW-1:0];
            state_next = S_WALK;
          end
        end
      end
      S_PUB: begin
        res_valid_next           = 1'b1;
        res_next.kind            = KIND_AVAIL;
        res_next.status          = ST_OK;
        res_next.slot_index      = 16'(avail_slot);
        res_next.desc_next       = chain_head;
        res_next.published_index = avail_index + 16'd1;
        res_next.last            = 1'b1;
        avail_index_next         = avail_index + 16'd1;
        // slot follows the free-running index modulo the queue size
        if (avail_index == 16'hffff || (QW'(avail_slot) + QW'(1)) == qsize)
          avail_slot_next = '0;
        else
          avail_slot_next = avail_slot + IW'(1);
        state_next = S_IDLE;
      end
      S_WALK: begin
        // give one descriptor back to the free list
        lw_en = 1'b1; lw_addr = h_cur; lw_data = fl_head;
        mw_en = 1'b1;
        fl_head_next = 16'(h_cur);
        if (free_count < qsize) free_count_next = free_count + QW'(1);
        steps_next = steps_inc;
        if (walk_done) begin
          res_valid_next      = 1'b1;
          res_next.kind       = KIND_POLL;
          res_next.status     = ST_OK;
          res_next.slot_index = cur.it.used_id;
          res_next.ret_token  = tok;
          res_next.ret_len    = cur.it.used_len;
          res_next.last       = 1'b1;
          used_seen_next      = used_seen + 16'd1;
          state_next          = S_IDLE;
        end else begin
          h_next        = link_eff[IW-1:0];
          rd_addr       = link_eff[IW-1:0];
          // a self link reads the entry being written this cycle
          fwd_next      = (link_eff[IW-1:0] == h_cur);
          fwd_link_next = fl_head;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // the first walk step runs on the entry read for the poll, h taken from used_id
  always_ff @(posedge clk) begin
    if (state == S_EXEC && cur.op == OP_POLL) h <= cur.it.used_id[IW-1:0];
    else h <= h_next;
  end

  always_ff @(posedge clk) begin
    link_rd <= link_mem[rd_addr];
    more_rd <= more_mem[rd_addr];
    tok_rd  <= tok_mem[rd_addr];
    if (lw_en) link_mem[lw_addr] <= lw_data;
    if (mw_en) more_mem[lw_addr] <= mw_data;
    if (tw_en) tok_mem[tw_addr]  <= tw_data;
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    steps    <= steps_next;
    fwd_link <= fwd_link_next;
    tok      <= tok_next;
    result   <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      qsize        <= map_size(rst ? QUEUE_SIZE_RESET : cfg_wdata);
      fl_head      <= '0;
      free_count   <= map_size(rst ? QUEUE_SIZE_RESET : cfg_wdata);
      avail_index  <= '0;
      avail_slot   <= '0;
      used_seen    <= '0;
      chain_pos    <= '0;
      chain_head   <= '0;
      chain_rej    <= 1'b0;
      fwd          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      clr_idx      <= clr_idx_next;
      fl_head      <= fl_head_next;
      free_count   <= free_count_next;
      avail_index  <= avail_index_next;
      avail_slot   <= avail_slot_next;
      used_seen    <= used_seen_next;
      chain_pos    <= chain_pos_next;
      chain_head   <= chain_head_next;
      chain_rej    <= chain_rej_next;
      fwd          <= fwd_next;
      result_valid <= res_valid_next;
    end
  end

  a_fc_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= qsize) else $error("free count above queue size");
  a_pub_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_PUB |-> $past(state == S_EXEC)) else $error("publish without add");
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst || cfg_we)
    state == S_CLEAR |=> !result_valid) else $error("result during clear");
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    QW'(avail_slot) < qsize) else $error("avail slot out of range");

endmodule
